// ----- rtl/core/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console character writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // Fixed field widths of the request and response transactions
   localparam int CMD_W     = 2;
   localparam int CODE_W    = 16;
   localparam int RD_ROW_W  = 5;
   localparam int RD_COL_W  = 6;
   localparam int CUR_ROW_W = 5;
   localparam int CUR_COL_W = 7;
   localparam int PHASE_W   = 2;

   // Control characters
   localparam logic [CODE_W-1:0] CODE_NUL     = 16'h0000;
   localparam logic [CODE_W-1:0] CODE_ESC     = 16'h001B;
   localparam logic [CODE_W-1:0] CODE_BRACKET = 16'h005B;
   localparam logic [CODE_W-1:0] CODE_ERASE   = 16'h004B;
   localparam logic [CODE_W-1:0] CODE_BS      = 16'h0008;
   localparam logic [CODE_W-1:0] CODE_LF      = 16'h000A;
   localparam logic [CODE_W-1:0] CODE_CR      = 16'h000D;

   typedef enum logic [CMD_W-1:0] {
      CMD_FEED  = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [PHASE_W-1:0] {
      PH_NORMAL  = 2'd0,
      PH_ESC     = 2'd1,
      PH_BRACKET = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_BACKSPACE,
      ACT_CR,
      ACT_LF,
      ACT_PUT,
      ACT_ERASE
   } action_type;

   // Decoded effect of one fed character
   typedef struct packed {
      action_type action;
      phase_type  next_phase;
   } decode_type;

endpackage

// ----- rtl/core/tcw_if.sv -----
// ----------------------------------------------------------------------------
// tcw_req_if / tcw_rsp_if
// Valid/ready channels carrying request and response transactions.
// ----------------------------------------------------------------------------
interface tcw_req_if;
   logic                                valid;
   logic                                ready;
   logic [tcw_pkg::CMD_W-1:0]           cmd;
   logic [tcw_pkg::CODE_W-1:0]          char_code;
   logic [tcw_pkg::RD_ROW_W-1:0]        read_row;
   logic [tcw_pkg::RD_COL_W-1:0]        read_col;

   modport source (output valid, output cmd, output char_code, output read_row,
                   output read_col, input ready);
   modport sink   (input valid, input cmd, input char_code, input read_row,
                   input read_col, output ready);
endinterface

interface tcw_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [tcw_pkg::CODE_W-1:0]          cell_value;
   logic [tcw_pkg::CUR_ROW_W-1:0]       cursor_row;
   logic [tcw_pkg::CUR_COL_W-1:0]       cursor_col;
   logic [tcw_pkg::PHASE_W-1:0]         escape_state;

   modport source (output valid, output cell_value, output cursor_row,
                   output cursor_col, output escape_state, input ready);
   modport sink   (input valid, input cell_value, input cursor_row,
                   input cursor_col, input escape_state, output ready);
endinterface

// ----- rtl/core/text_console_char_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_char_writer
// Character-cell text console with cursor, escape handling and erase-line.
// ----------------------------------------------------------------------------
// Sequence: an accepted feed, read or no-op goes to ST_DONE, which loads the
//   response register once it is free; ESC [ K and clear first sweep the erased
//   cells or the whole store to zero. A new transaction is taken only in ST_IDLE;
//   a response waiting in the output register does not block the next request.
// Reset: synchronous; cursor and escape phase go to zero, then all ROWS*COLS cells
//   (2048 by default) of the store are swept to zero with req ready low.
// ----------------------------------------------------------------------------
module text_console_char_writer #(
   parameter int ROWS      = 32,
   parameter int COLS      = 64,
   parameter int CHAR_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   tcw_req_if.sink   req_chan,
   tcw_rsp_if.source rsp_chan
);

   // cell store is linear, row-major: addr = row * COLS + col
   localparam int DEPTH = ROWS * COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [CHAR_BITS-1:0] ram_wdata;
   logic                 ram_re;
   logic [AW-1:0]        ram_raddr;
   logic [CHAR_BITS-1:0] ram_rdata;

   // Sequencer: decodes each transaction, keeps cursor and escape phase,
   // runs clear and erase sweeps one cell per cycle, and holds the response
   // register so the next request can be taken while a response waits.
   tcw_ctrl #(
      .ROWS      (ROWS),
      .COLS      (COLS),
      .CHAR_BITS (CHAR_BITS),
      .AW        (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   // Cell store: registered read data; read data is only captured for
   // in-range read commands and holds until the response is loaded.
   tcw_text_ram #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (CHAR_BITS)
   ) u_text_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

endmodule

// ----- rtl/core/tcw_char_decode.sv -----
// ----------------------------------------------------------------------------
// tcw_char_decode
// Classifies a fed character against the escape phase.
// ----------------------------------------------------------------------------
module tcw_char_decode (
   input  logic [tcw_pkg::CODE_W-1:0] char_code,
   input  tcw_pkg::phase_type         phase,
   output tcw_pkg::decode_type        decode
);

   always_comb begin
      decode.action     = tcw_pkg::ACT_NONE;
      decode.next_phase = phase;
      if (char_code != tcw_pkg::CODE_NUL) begin
         unique case (phase)
            tcw_pkg::PH_ESC: begin
               decode.next_phase = (char_code == tcw_pkg::CODE_BRACKET) ?
                                   tcw_pkg::PH_BRACKET : tcw_pkg::PH_NORMAL;
            end
            tcw_pkg::PH_BRACKET: begin
               decode.next_phase = tcw_pkg::PH_NORMAL;
               if (char_code == tcw_pkg::CODE_ERASE) begin
                  decode.action = tcw_pkg::ACT_ERASE;
               end
            end
            default: begin
               priority if (char_code == tcw_pkg::CODE_ESC) begin
                  decode.next_phase = tcw_pkg::PH_ESC;
               end else if (char_code == tcw_pkg::CODE_BS) begin
                  decode.action = tcw_pkg::ACT_BACKSPACE;
               end else if (char_code == tcw_pkg::CODE_CR) begin
                  decode.action = tcw_pkg::ACT_CR;
               end else if (char_code == tcw_pkg::CODE_LF) begin
                  decode.action = tcw_pkg::ACT_LF;
               end else begin
                  decode.action = tcw_pkg::ACT_PUT;
               end
            end
         endcase
      end
   end

endmodule

// ----- rtl/core/tcw_text_ram.sv -----
// ----------------------------------------------------------------------------
// tcw_text_ram
// Character cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_text_ram #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11,
   parameter int DW    = 16
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] cells_mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= cells_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/tcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcw_ctrl
// Command sequencer: cursor, escape phase, store sweeps and result register.
// ----------------------------------------------------------------------------
module tcw_ctrl #(
   parameter int ROWS      = 32,
   parameter int COLS      = 64,
   parameter int CHAR_BITS = 16,
   parameter int AW        = 11
) (
   input  logic                 clock,
   input  logic                 reset,
   tcw_req_if.sink              req,
   tcw_rsp_if.source            rsp,
   output logic                 ram_we,
   output logic [AW-1:0]        ram_waddr,
   output logic [CHAR_BITS-1:0] ram_wdata,
   output logic                 ram_re,
   output logic [AW-1:0]        ram_raddr,
   input  logic [CHAR_BITS-1:0] ram_rdata
);

   localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CW = $clog2(COLS + 1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ERASE,
      ST_DONE
   } state_type;

   state_type                    state_ff;
   logic [AW-1:0]                sweep_ff;
   logic [AW-1:0]                sweep_end_ff;
   logic                         clear_cmd_ff;
   logic                         cell_sel_ff;
   logic [RW-1:0]                row_ff;
   logic [CW-1:0]                col_ff;
   tcw_pkg::phase_type           phase_ff;
   logic                         rsp_valid_ff;
   logic [tcw_pkg::CODE_W-1:0]   rsp_cell_ff;
   logic [tcw_pkg::CUR_ROW_W-1:0] rsp_row_ff;
   logic [tcw_pkg::CUR_COL_W-1:0] rsp_col_ff;
   logic [tcw_pkg::PHASE_W-1:0]  rsp_phase_ff;

   tcw_pkg::cmd_type             cmd;
   tcw_pkg::decode_type          dec;
   logic                         accept;
   logic                         line_full;
   logic                         read_hit;
   logic                         rsp_free;
   logic [AW-1:0]                row_base;
   logic [AW-1:0]                cur_addr;
   logic [AW-1:0]                rd_addr;

   tcw_char_decode u_decode (
      .char_code (req.char_code),
      .phase     (phase_ff),
      .decode    (dec)
   );

   assign cmd       = tcw_pkg::cmd_type'(req.cmd);
   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && (state_ff == ST_IDLE);
   assign line_full = (col_ff == CW'(COLS));
   assign rsp_free  = !rsp_valid_ff || rsp.ready;

   assign read_hit = (9'(req.read_row) < 9'(ROWS)) && (9'(req.read_col) < 9'(COLS));
   assign row_base = AW'(row_ff) * AW'(COLS);
   assign cur_addr = row_base + AW'(col_ff);
   assign rd_addr  = AW'(req.read_row) * AW'(COLS) + AW'(req.read_col);

   // write port: sweeps write zero, printable characters land at the cursor
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = sweep_ff;
      ram_wdata = '0;
      if (state_ff == ST_CLEAR || state_ff == ST_ERASE) begin
         ram_we = 1'b1;
      end else if (accept && cmd == tcw_pkg::CMD_FEED &&
                   dec.action == tcw_pkg::ACT_PUT && !line_full) begin
         ram_we    = 1'b1;
         ram_waddr = cur_addr;
         ram_wdata = CHAR_BITS'(req.char_code);
      end
   end

   assign ram_re    = accept && (cmd == tcw_pkg::CMD_READ) && read_hit;
   assign ram_raddr = rd_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         sweep_end_ff <= '0;
         clear_cmd_ff <= 1'b0;
         cell_sel_ff  <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         phase_ff     <= tcw_pkg::PH_NORMAL;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in ST_DONE the response register is reloaded below instead
         if (rsp.ready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               if (sweep_ff == AW'(ROWS * COLS - 1)) begin
                  state_ff <= clear_cmd_ff ? ST_DONE : ST_IDLE;
               end else begin
                  sweep_ff <= sweep_ff + 1'b1;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  cell_sel_ff <= (cmd == tcw_pkg::CMD_READ) && read_hit;
                  state_ff    <= ST_DONE;
                  unique case (cmd)
                     tcw_pkg::CMD_FEED: begin
                        phase_ff <= dec.next_phase;
                        unique case (dec.action)
                           tcw_pkg::ACT_BACKSPACE: begin
                              if (col_ff != '0) begin
                                 col_ff <= col_ff - 1'b1;
                              end
                           end
                           tcw_pkg::ACT_CR: begin
                              col_ff <= '0;
                           end
                           tcw_pkg::ACT_LF: begin
                              if (row_ff != RW'(ROWS - 1)) begin
                                 row_ff <= row_ff + 1'b1;
                                 col_ff <= '0;
                              end
                           end
                           tcw_pkg::ACT_PUT: begin
                              if (!line_full) begin
                                 col_ff <= col_ff + 1'b1;
                              end
                           end
                           tcw_pkg::ACT_ERASE: begin
                              if (!line_full) begin
                                 sweep_ff     <= cur_addr;
                                 sweep_end_ff <= row_base + AW'(COLS - 1);
                                 state_ff     <= ST_ERASE;
                              end
                           end
                           default: begin
                           end
                        endcase
                     end
                     tcw_pkg::CMD_CLEAR: begin
                        row_ff       <= '0;
                        col_ff       <= '0;
                        sweep_ff     <= '0;
                        clear_cmd_ff <= 1'b1;
                        state_ff     <= ST_CLEAR;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_ERASE: begin
               if (sweep_ff == sweep_end_ff) begin
                  state_ff <= ST_DONE;
               end else begin
                  sweep_ff <= sweep_ff + 1'b1;
               end
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_cell_ff  <= cell_sel_ff ? tcw_pkg::CODE_W'(ram_rdata) : '0;
                  rsp_row_ff   <= tcw_pkg::CUR_ROW_W'(row_ff);
                  rsp_col_ff   <= tcw_pkg::CUR_COL_W'(col_ff);
                  rsp_phase_ff <= phase_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.cell_value   = rsp_cell_ff;
   assign rsp.cursor_row   = rsp_row_ff;
   assign rsp.cursor_col   = rsp_col_ff;
   assign rsp.escape_state = rsp_phase_ff;

   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      col_ff <= CW'(COLS))
      else $error("cursor column beyond line end");

   a_clear_homes: assert property (@(posedge clock) disable iff (reset)
      (accept && cmd == tcw_pkg::CMD_CLEAR) |=>
      (row_ff == '0 && col_ff == '0 && state_ff == ST_CLEAR))
      else $error("clear did not home cursor and start sweep");

   a_port_excl: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("store written and read in the same cycle");

   a_done_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result not loaded when output register was free");

endmodule

// ----- bench/text_console_char_writer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer_tb
// Drives character, clear, read and no-op transactions into the console and
// checks every response against a cycle-free behavioral copy of the console.
// Directed corner cases run first, then random text, newline, backspace,
// erase-line and broken escape sequences with random cell reads, no-ops, clears and raw noise.
// ----------------------------------------------------------------------------
module text_console_char_writer_tb;

   localparam int ROWS        = 32;
   localparam int COLS        = 64;
   localparam int RANDOM_GOAL = 1425;   // random transactions after the directed part
   localparam int CHUNKS      = 4;      // random part is split; the feed drains between
   localparam int STALL_LIMIT = 20000;  // longer than a clear or the reset sweep of the whole store
   localparam int TAIL_CYCLES = 24;

   typedef struct packed {
      tcw_pkg::cmd_type cmd;
      logic [15:0]      code;
      logic [4:0]       row;
      logic [5:0]       col;
   } console_req_type;

   typedef struct packed {
      logic [15:0]        cell_val;
      logic [4:0]         row;
      logic [6:0]         col;
      tcw_pkg::phase_type phase;
   } console_view_type;

   logic clock;
   logic reset;

   tcw_req_if req_chan ();
   tcw_rsp_if rsp_chan ();

   text_console_char_writer #(
      .ROWS      (ROWS),
      .COLS      (COLS),
      .CHAR_BITS (16)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow console: cell store, cursor and escape phase
   logic [15:0]        screen_cells [ROWS][COLS];
   int                 cur_row;
   int                 cur_col;
   tcw_pkg::phase_type esc_phase;

   console_req_type  console_requests  [$];   // transactions still to be driven
   console_view_type predicted_replies [$];   // expected responses, oldest first

   int err_count;
   int total_queued;
   int req_accepts;
   int idle_cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Shadow model
   // ------------------------------------------------------------------------
   function automatic void blank_screen();
      for (int r = 0; r < ROWS; r++)
         for (int c = 0; c < COLS; c++)
            screen_cells[r][c] = '0;
   endfunction

   // Applies one transaction to the shadow console, returns what the DUT
   // should answer with.
   function automatic console_view_type apply_console_request(input console_req_type rq);
      console_view_type view;
      view.cell_val = '0;
      case (rq.cmd)
         tcw_pkg::CMD_FEED: begin
            if (rq.code == tcw_pkg::CODE_NUL) begin
               // NUL is dropped in every phase, phase kept
            end else if (esc_phase == tcw_pkg::PH_ESC) begin
               esc_phase = (rq.code == tcw_pkg::CODE_BRACKET) ? tcw_pkg::PH_BRACKET
                                                              : tcw_pkg::PH_NORMAL;
            end else if (esc_phase == tcw_pkg::PH_BRACKET) begin
               if (rq.code == tcw_pkg::CODE_ERASE)
                  for (int c = cur_col; c < COLS; c++)
                     screen_cells[cur_row][c] = '0;
               esc_phase = tcw_pkg::PH_NORMAL;
            end else if (rq.code == tcw_pkg::CODE_ESC) begin
               esc_phase = tcw_pkg::PH_ESC;
            end else if (rq.code == tcw_pkg::CODE_BS) begin
               if (cur_col > 0)
                  cur_col--;
            end else if (rq.code == tcw_pkg::CODE_CR) begin
               cur_col = 0;
            end else if (rq.code == tcw_pkg::CODE_LF) begin
               // on the bottom row a newline does nothing at all
               if (cur_row + 1 < ROWS) begin
                  cur_row++;
                  cur_col = 0;
               end
            end else if (cur_col < COLS) begin
               screen_cells[cur_row][cur_col] = rq.code;
               cur_col++;
            end
         end
         tcw_pkg::CMD_CLEAR: begin
            blank_screen();
            cur_row = 0;
            cur_col = 0;
         end
         tcw_pkg::CMD_READ: begin
            if (rq.row < ROWS && rq.col < COLS)
               view.cell_val = screen_cells[rq.row][rq.col];
         end
         default: ;
      endcase
      view.row   = cur_row[4:0];
      view.col   = cur_col[6:0];
      view.phase = esc_phase;
      return view;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic void queue_request(input tcw_pkg::cmd_type c,
                                         input logic [15:0] code,
                                         input logic [4:0] r, input logic [5:0] col);
      console_req_type rq;
      rq.cmd  = c;
      rq.code = code;
      rq.row  = r;
      rq.col  = col;
      console_requests.push_back(rq);
      total_queued++;
   endfunction

   // Row/col fields are don't-care on a feed; randomize them anyway
   function automatic void queue_feed(input logic [15:0] code);
      queue_request(tcw_pkg::CMD_FEED, code, 5'($urandom), 6'($urandom));
   endfunction

   // Mostly plain ASCII, sometimes any nonzero 16-bit code
   function automatic logic [15:0] random_glyph();
      if ($urandom_range(0, 3) == 0)
         return 16'($urandom_range(1, 16'hFFFF));
      return 16'($urandom_range(16'h20, 16'h7E));
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
      err_count++;
   endtask

   // No idling while the accepted count sits in this window
   function automatic bit calm_window();
      return req_accepts >= 500 && req_accepts < 800;
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: predicts on acceptance, then offers the next transaction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      console_req_type taken;
      console_req_type next_req;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            taken.cmd  = tcw_pkg::cmd_type'(req_chan.cmd);
            taken.code = req_chan.char_code;
            taken.row  = req_chan.read_row;
            taken.col  = req_chan.read_col;
            predicted_replies.push_back(apply_console_request(taken));
            req_accepts++;
         end
         // slot is free when nothing is offered or the offer just went through
         if (!req_chan.valid || req_chan.ready) begin
            if (console_requests.size() != 0 &&
                (calm_window() || $urandom_range(0, 99) >= 26)) begin
               next_req = console_requests.pop_front();
               req_chan.valid     <= 1'b1;
               req_chan.cmd       <= next_req.cmd;
               req_chan.char_code <= next_req.code;
               req_chan.read_row  <= next_req.row;
               req_chan.read_col  <= next_req.col;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor: field-by-field compare against the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      console_view_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (predicted_replies.size() == 0) begin
               report_mismatch("response with nothing outstanding", rsp_chan.cursor_col, 0);
            end else begin
               want = predicted_replies.pop_front();
               if (rsp_chan.cell_value !== want.cell_val)
                  report_mismatch("cell_value", rsp_chan.cell_value, want.cell_val);
               if (rsp_chan.cursor_row !== want.row)
                  report_mismatch("cursor_row", rsp_chan.cursor_row, want.row);
               if (rsp_chan.cursor_col !== want.col)
                  report_mismatch("cursor_col", rsp_chan.cursor_col, want.col);
               if (rsp_chan.escape_state !== want.phase)
                  report_mismatch("escape_state", rsp_chan.escape_state, want.phase);
            end
         end
         rsp_chan.ready <= calm_window() || $urandom_range(0, 99) >= 26;
      end
   end

   // Watchdog: cycles in which no transaction moves on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < STALL_LIMIT)
         @(posedge clock);
      $display("** text_console_char_writer: FAILED **");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      int pick;
      int n;
      int pre_count;

      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.cmd       = tcw_pkg::CMD_NOP;
      req_chan.char_code = '0;
      req_chan.read_row  = '0;
      req_chan.read_col  = '0;
      rsp_chan.ready     = 1'b0;
      err_count    = 0;
      total_queued = 0;
      req_accepts  = 0;
      idle_cycles  = 0;
      blank_screen();
      cur_row   = 0;
      cur_col   = 0;
      esc_phase = tcw_pkg::PH_NORMAL;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed corner cases
      queue_request(tcw_pkg::CMD_NOP, 16'hFFFF, 5'd31, 6'd63);   // no-op, all bits high
      queue_feed(tcw_pkg::CODE_NUL);                              // NUL ignored
      queue_feed(16'hFFFF);                                       // top code stored
      queue_feed(16'h0001);                                       // lowest printable
      queue_request(tcw_pkg::CMD_READ, 16'hFFFF, 5'd0, 6'd0);     // code ignored on a read
      queue_feed(tcw_pkg::CODE_BS);
      queue_feed(16'h0041);                                       // overwrite after BS
      queue_feed(tcw_pkg::CODE_CR);
      queue_feed(tcw_pkg::CODE_ESC);
      queue_feed(tcw_pkg::CODE_NUL);                              // NUL keeps ESC phase
      queue_feed(tcw_pkg::CODE_BRACKET);
      queue_feed(tcw_pkg::CODE_NUL);                              // NUL keeps bracket phase
      queue_feed(tcw_pkg::CODE_ERASE);                            // erase the first row
      queue_request(tcw_pkg::CMD_READ, 16'h0000, 5'd0, 6'd1);
      queue_feed(tcw_pkg::CODE_ESC);
      queue_feed(16'h0078);                                       // swallowed after ESC
      queue_feed(tcw_pkg::CODE_ESC);
      queue_feed(tcw_pkg::CODE_BRACKET);
      queue_feed(16'h007A);                                       // swallowed after ESC [
      queue_feed(tcw_pkg::CODE_LF);
      queue_feed(tcw_pkg::CODE_BS);                               // backspace at column 0
      queue_request(tcw_pkg::CMD_READ, 16'h0000, 5'd31, 6'd63);
      queue_request(tcw_pkg::CMD_CLEAR, 16'hFFFF, 5'd31, 6'd63);
      queue_feed(tcw_pkg::CODE_LF);
      pre_count = total_queued;

      for (int chunk = 0; chunk < CHUNKS; chunk++) begin
         // hold off until everything sent so far has come back
         while (console_requests.size() != 0 || req_chan.valid ||
                predicted_replies.size() != 0)
            @(posedge clock);

         while (total_queued < pre_count + (chunk + 1) * RANDOM_GOAL / CHUNKS) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
               n = $urandom_range(1, 12);
               repeat (n) queue_feed(random_glyph());
            end else if (pick < 34) begin
               // long line: runs into the full-line column and beyond
               n = $urandom_range(56, 72);
               repeat (n) queue_feed(random_glyph());
            end else if (pick < 44) begin
               // occasionally a long newline burst to hit the bottom row
               n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 34) : $urandom_range(1, 3);
               if ($urandom_range(0, 1))
                  queue_feed(tcw_pkg::CODE_CR);
               repeat (n) queue_feed(tcw_pkg::CODE_LF);
            end else if (pick < 50) begin
               queue_feed(tcw_pkg::CODE_CR);
            end else if (pick < 58) begin
               n = $urandom_range(1, 6);
               repeat (n) queue_feed(tcw_pkg::CODE_BS);
               if ($urandom_range(0, 1))
                  queue_feed(random_glyph());
            end else if (pick < 70) begin
               // erase to end of line from a moved cursor
               case ($urandom_range(0, 2))
                  0: queue_feed(tcw_pkg::CODE_CR);
                  1: repeat ($urandom_range(1, 8)) queue_feed(tcw_pkg::CODE_BS);
                  default: ;
               endcase
               queue_feed(tcw_pkg::CODE_ESC);
               queue_feed(tcw_pkg::CODE_BRACKET);
               queue_feed(tcw_pkg::CODE_ERASE);
            end else if (pick < 76) begin
               // broken or padded escape sequences
               queue_feed(tcw_pkg::CODE_ESC);
               case ($urandom_range(0, 3))
                  0: queue_feed(random_glyph());
                  1: begin
                     queue_feed(tcw_pkg::CODE_BRACKET);
                     queue_feed(random_glyph());
                  end
                  2: begin
                     queue_feed(tcw_pkg::CODE_NUL);
                     queue_feed(tcw_pkg::CODE_BRACKET);
                     queue_feed(tcw_pkg::CODE_NUL);
                     queue_feed(tcw_pkg::CODE_ERASE);
                  end
                  default: queue_feed(tcw_pkg::CODE_ESC);
               endcase
            end else if (pick < 90) begin
               n = $urandom_range(1, 4);
               repeat (n)
                  queue_request(tcw_pkg::CMD_READ, 16'($urandom),
                                5'($urandom_range(0, 31)),
                                $urandom_range(0, 1) ? 6'($urandom_range(0, 63))
                                                     : 6'($urandom_range(0, 15)));
            end else if (pick < 92) begin
               queue_request(tcw_pkg::CMD_NOP, 16'($urandom), 5'($urandom), 6'($urandom));
            end else if (pick < 93) begin
               queue_request(tcw_pkg::CMD_CLEAR, 16'($urandom), 5'($urandom), 6'($urandom));
            end else begin
               // raw noise on every field
               queue_request(tcw_pkg::cmd_type'($urandom_range(0, 3)), 16'($urandom),
                             5'($urandom), 6'($urandom));
            end
         end
      end

      while (console_requests.size() != 0 || req_chan.valid ||
             predicted_replies.size() != 0)
         @(posedge clock);
      // catch any stray response after the last expected one
      repeat (TAIL_CYCLES) @(posedge clock);

      if (err_count == 0)
         $display("** text_console_char_writer: PASSED **");
      else
         $display("** text_console_char_writer: FAILED **");
      $finish;
   end

endmodule
